// ----- rtl/core/ttd_pkg.sv -----
// shared types, codes and microcode table of the time-triggered task dispatcher
`timescale 1ns / 1ps
package ttd_pkg;

    // payload widths
    localparam int ACTION_W = 2;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int RES_LIMIT      = 9;
    localparam int NRES_W         = 4;

    // reset values of the configuration registers
    localparam logic [WORD_W-1:0] MACRO_PERIOD_RST   = 32'd999;
    localparam logic [WORD_W-1:0] EXPECTED_TS_RST    = 32'd500;
    localparam logic [WORD_W-1:0] MAX_CORRECTION_RST = 32'd50;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MACRO_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORRECTION = 2'd2;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ADD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SYNC = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DUE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELOAD = 2'd2;

    // add answer status
    localparam logic ST_ACCEPTED = 1'b0;
    localparam logic ST_FULL     = 1'b1;

    // datapath operations of a control word
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
    localparam logic [OP_W-1:0] OP_RESTORE = 4'd1;
    localparam logic [OP_W-1:0] OP_DUE     = 4'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 4'd3;
    localparam logic [OP_W-1:0] OP_SEARCH  = 4'd4;
    localparam logic [OP_W-1:0] OP_TAKE    = 4'd5;
    localparam logic [OP_W-1:0] OP_DIFF    = 4'd6;
    localparam logic [OP_W-1:0] OP_CLAMP   = 4'd7;
    localparam logic [OP_W-1:0] OP_APPLY   = 4'd8;
    localparam logic [OP_W-1:0] OP_NOTE    = 4'd9;

    // sequencing of a control word
    localparam int JMP_W = 2;
    localparam logic [JMP_W-1:0] JMP_NEXT = 2'd0;
    localparam logic [JMP_W-1:0] JMP_GOTO = 2'd1;
    localparam logic [JMP_W-1:0] JMP_MORE = 2'd2;  // loop while slots remain
    localparam logic [JMP_W-1:0] JMP_BUSY = 2'd3;  // loop while slot used and slots remain

    // program addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_T_RESTORE = 4'd1;
    localparam logic [PC_W-1:0] PC_T_WALK   = 4'd2;
    localparam logic [PC_W-1:0] PC_FLUSH    = 4'd3;
    localparam logic [PC_W-1:0] PC_A_SEARCH = 4'd4;
    localparam logic [PC_W-1:0] PC_A_TAKE   = 4'd5;
    localparam logic [PC_W-1:0] PC_S_DIFF   = 4'd6;
    localparam logic [PC_W-1:0] PC_S_CLAMP  = 4'd7;
    localparam logic [PC_W-1:0] PC_S_APPLY  = 4'd8;
    localparam logic [PC_W-1:0] PC_S_NOTE   = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [JMP_W-1:0] jmp;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    function automatic t_ctrl ttd_ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, jmp: JMP_GOTO, target: PC_IDLE};
        case (pc)
            PC_IDLE:      w = '{op: OP_NOP,     jmp: JMP_GOTO, target: PC_IDLE};
            PC_T_RESTORE: w = '{op: OP_RESTORE, jmp: JMP_NEXT, target: PC_IDLE};
            PC_T_WALK:    w = '{op: OP_DUE,     jmp: JMP_MORE, target: PC_T_WALK};
            PC_FLUSH:     w = '{op: OP_FLUSH,   jmp: JMP_GOTO, target: PC_IDLE};
            PC_A_SEARCH:  w = '{op: OP_SEARCH,  jmp: JMP_BUSY, target: PC_A_SEARCH};
            PC_A_TAKE:    w = '{op: OP_TAKE,    jmp: JMP_GOTO, target: PC_FLUSH};
            PC_S_DIFF:    w = '{op: OP_DIFF,    jmp: JMP_NEXT, target: PC_IDLE};
            PC_S_CLAMP:   w = '{op: OP_CLAMP,   jmp: JMP_NEXT, target: PC_IDLE};
            PC_S_APPLY:   w = '{op: OP_APPLY,   jmp: JMP_NEXT, target: PC_IDLE};
            PC_S_NOTE:    w = '{op: OP_NOTE,    jmp: JMP_GOTO, target: PC_FLUSH};
            default:      w = '{op: OP_NOP,     jmp: JMP_GOTO, target: PC_IDLE};
        endcase
        return w;
    endfunction

    // program entry for each action, undefined actions stay idle
    function automatic logic [PC_W-1:0] ttd_entry(input logic [ACTION_W-1:0] action);
        logic [PC_W-1:0] pc;
        pc = PC_IDLE;
        case (action)
            ACT_TICK: pc = PC_T_RESTORE;
            ACT_ADD:  pc = PC_A_SEARCH;
            ACT_SYNC: pc = PC_S_DIFF;
            default:  pc = PC_IDLE;
        endcase
        return pc;
    endfunction

endpackage

// ----- rtl/core/ttd_in_if.sv -----
// request channel of the dispatcher: action and task or sync fields
`timescale 1ns / 1ps
interface ttd_in_if;
    import ttd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [WORD_W-1:0]   initial_delay;
    logic [WORD_W-1:0]   period;
    logic [WORD_W-1:0]   rx_timestamp;

    modport source (
        output valid, action, initial_delay, period, rx_timestamp,
        input  ready
    );
    modport sink (
        input  valid, action, initial_delay, period, rx_timestamp,
        output ready
    );
endinterface

// ----- rtl/core/ttd_out_if.sv -----
// result channel of the dispatcher: due events, add answers, reload changes
`timescale 1ns / 1ps
interface ttd_out_if;
    import ttd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic [WORD_W-1:0] reload_value;
    logic              last;

    modport source (
        output valid, kind, slot, status, reload_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, slot, status, reload_value, last,
        output ready
    );
endinterface

// ----- rtl/core/time_triggered_task_dispatcher_unit.sv -----
// time-triggered task dispatcher: microcoded sequencer over a task slot table
// usage:
//   i_req carries one request: a tick, an add task or a sync message. o_res
//   returns the results of that request one per transfer, the final one with
//   last set; a quiet tick or an undefined action returns nothing.
//   configuration (macro period, expected timestamp, max correction) is
//   written on i_cfg_we / i_cfg_idx / i_cfg_data while no request is in work.
// sequencing:
//   one request at a time; the step counter walks a 10-word control store.
//   tick: restore, one slot per cycle unless the output stalls, flush
//   add: free-slot search one slot per cycle unless the output stalls, take, flush
//   sync: difference, clamp, saturating apply, note, flush
//   results are held in a staging register until the next result or the
//   flush, so that last can be marked.
// stall: a held output register freezes the sequencer until o_res.ready;
//   nothing is dropped. a new request is taken while a result still waits.
// reset: slot table empty, no correction pending, reload and configuration
//   at their defaults (reload 999).
`timescale 1ns / 1ps
module time_triggered_task_dispatcher_unit #(
    parameter int TASK_SLOTS = ttd_pkg::TASK_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ttd_pkg::WORD_W-1:0]    i_cfg_data,
    ttd_in_if.sink                        i_req,
    ttd_out_if.source                     o_res
);
    import ttd_pkg::*;

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TASK_SLOTS - 1);

    // configuration
    logic [WORD_W-1:0] r_macro;
    logic [WORD_W-1:0] r_expected;
    logic [WORD_W-1:0] r_max_corr;

    // sequencer
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [NRES_W-1:0] r_nres;

    // slot table
    logic              r_used [TASK_SLOTS];
    logic [WORD_W-1:0] r_cd   [TASK_SLOTS];
    logic [WORD_W-1:0] r_rp   [TASK_SLOTS];

    // request fields and sync datapath
    logic [WORD_W-1:0] r_delay;
    logic [WORD_W-1:0] r_period;
    logic [WORD_W-1:0] r_rx;
    logic [WORD_W-1:0] r_diff;
    logic              r_raise;
    logic              r_pending;
    logic [WORD_W-1:0] r_reload;

    // staging and output registers
    logic              r_hold_valid;
    logic [KIND_W-1:0] r_hold_kind;
    logic [SLOT_W-1:0] r_hold_slot;
    logic              r_hold_status;
    logic [WORD_W-1:0] r_hold_reload;
    logic              r_out_valid;
    logic [KIND_W-1:0] r_out_kind;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_status;
    logic [WORD_W-1:0] r_out_reload;
    logic              r_out_last;

    t_ctrl               w_ctrl;
    logic                w_accept;
    logic                w_go;
    logic                w_used_cur;
    logic [WORD_W-1:0]   w_cd_cur;
    logic                w_cd_low;
    logic                w_at_last;
    logic [SLOT_W+IDX_W-1:0] w_idx_ext;
    logic [SLOT_W-1:0]   w_slot_cur;
    logic                w_stash_req;
    logic                w_stash;
    logic [KIND_W-1:0]   w_st_kind;
    logic [SLOT_W-1:0]   w_st_slot;
    logic                w_st_status;
    logic [WORD_W-1:0]   w_st_reload;
    logic                w_push;
    logic                w_flush;
    logic [WORD_W:0]     w_sub_a;
    logic [WORD_W:0]     w_sub_b;
    logic                w_rx_above;
    logic [WORD_W:0]     w_up;
    logic [WORD_W:0]     w_dn;
    logic [WORD_W-1:0]   w_new_reload;

    assign w_ctrl     = ttd_ucode(r_pc);
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_go       = (r_pc != PC_IDLE) && (!r_out_valid || o_res.ready);
    assign w_used_cur = r_used[r_idx];
    assign w_cd_cur   = r_cd[r_idx];
    assign w_cd_low   = (w_cd_cur[WORD_W-1:1] == '0);
    assign w_at_last  = (r_idx == IDX_LAST);
    assign w_idx_ext  = {{SLOT_W{1'b0}}, r_idx};
    assign w_slot_cur = w_idx_ext[SLOT_W-1:0];

    assign i_req.ready = (r_pc == PC_IDLE);

    // sync arithmetic
    assign w_sub_a    = {1'b0, r_rx} - {1'b0, r_expected};
    assign w_sub_b    = {1'b0, r_expected} - {1'b0, r_rx};
    assign w_rx_above = !w_sub_a[WORD_W] && (w_sub_a[WORD_W-1:0] != '0);
    assign w_up       = {1'b0, r_macro} + {1'b0, r_diff};
    assign w_dn       = {1'b0, r_macro} - {1'b0, r_diff};

    always_comb begin
        if (r_raise) begin
            w_new_reload = w_up[WORD_W] ? '1 : w_up[WORD_W-1:0];
        end else begin
            w_new_reload = w_dn[WORD_W] ? '0 : w_dn[WORD_W-1:0];
        end
    end

    // result produced by the current step
    always_comb begin
        w_stash_req = 1'b0;
        w_st_kind   = KIND_RELOAD;
        w_st_slot   = '0;
        w_st_status = ST_ACCEPTED;
        w_st_reload = r_reload;
        case (w_ctrl.op)
            OP_RESTORE: begin
                w_stash_req = r_pending;
                w_st_reload = r_macro;
            end
            OP_DUE: begin
                w_stash_req = w_used_cur && w_cd_low;
                w_st_kind   = KIND_DUE;
                w_st_slot   = w_slot_cur;
            end
            OP_TAKE: begin
                w_stash_req = 1'b1;
                w_st_kind   = KIND_ADD;
                w_st_slot   = w_used_cur ? '0 : w_slot_cur;
                w_st_status = w_used_cur ? ST_FULL : ST_ACCEPTED;
            end
            OP_NOTE: begin
                w_stash_req = 1'b1;
            end
            default: begin
                w_stash_req = 1'b0;
            end
        endcase
    end

    assign w_stash = w_go && w_stash_req && (r_nres < NRES_W'(RES_LIMIT));
    assign w_push  = w_stash && r_hold_valid;
    assign w_flush = w_go && (w_ctrl.op == OP_FLUSH) && r_hold_valid;

    // next step and slot index
    always_comb begin
        n_pc  = r_pc;
        n_idx = r_idx;
        if (w_accept) begin
            n_pc  = ttd_entry(i_req.action);
            n_idx = '0;
        end else if (w_go) begin
            case (w_ctrl.jmp)
                JMP_NEXT: n_pc = r_pc + 1'b1;
                JMP_GOTO: n_pc = w_ctrl.target;
                JMP_MORE: n_pc = w_at_last ? r_pc + 1'b1 : w_ctrl.target;
                JMP_BUSY: n_pc = (w_used_cur && !w_at_last) ? w_ctrl.target : r_pc + 1'b1;
                default:  n_pc = PC_IDLE;
            endcase
            if ((w_ctrl.op == OP_DUE && !w_at_last) ||
                (w_ctrl.op == OP_SEARCH && w_used_cur && !w_at_last)) begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= PC_IDLE;
            r_idx        <= '0;
            r_nres       <= '0;
            r_macro      <= MACRO_PERIOD_RST;
            r_expected   <= EXPECTED_TS_RST;
            r_max_corr   <= MAX_CORRECTION_RST;
            r_pending    <= 1'b0;
            r_reload     <= MACRO_PERIOD_RST;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_used[k] <= 1'b0;
            end
        end else begin
            r_pc  <= n_pc;
            r_idx <= n_idx;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MACRO_PERIOD:   r_macro    <= i_cfg_data;
                    REG_EXPECTED_TS:    r_expected <= i_cfg_data;
                    REG_MAX_CORRECTION: r_max_corr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_nres <= '0;
            end else if (w_stash) begin
                r_nres <= r_nres + 1'b1;
            end
            if (w_go && w_ctrl.op == OP_RESTORE && r_pending) begin
                r_pending <= 1'b0;
                r_reload  <= r_macro;
            end
            if (w_go && w_ctrl.op == OP_APPLY) begin
                r_pending <= 1'b1;
                r_reload  <= w_new_reload;
            end
            if (w_go && w_ctrl.op == OP_TAKE && !w_used_cur) begin
                r_used[r_idx] <= 1'b1;
            end
            if (w_stash) begin
                r_hold_valid <= 1'b1;
            end else if (w_flush) begin
                r_hold_valid <= 1'b0;
            end
            if (w_push || w_flush) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and slot table contents
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_delay  <= i_req.initial_delay;
            r_period <= i_req.period;
            r_rx     <= i_req.rx_timestamp;
        end
        if (w_go && w_ctrl.op == OP_DIFF) begin
            r_raise <= w_rx_above;
            r_diff  <= w_rx_above ? w_sub_a[WORD_W-1:0] : w_sub_b[WORD_W-1:0];
        end
        if (w_go && w_ctrl.op == OP_CLAMP && r_diff > r_max_corr) begin
            r_diff <= r_max_corr;
        end
        if (w_go && w_ctrl.op == OP_DUE && w_used_cur) begin
            // a countdown of zero or one is due now and reloads
            r_cd[r_idx] <= w_cd_low ? r_rp[r_idx] : w_cd_cur - 1'b1;
        end
        if (w_go && w_ctrl.op == OP_TAKE && !w_used_cur) begin
            r_cd[r_idx] <= r_delay;
            r_rp[r_idx] <= r_period;
        end
        if (w_stash) begin
            r_hold_kind   <= w_st_kind;
            r_hold_slot   <= w_st_slot;
            r_hold_status <= w_st_status;
            r_hold_reload <= w_st_reload;
        end
        if (w_push || w_flush) begin
            r_out_kind   <= r_hold_kind;
            r_out_slot   <= r_hold_slot;
            r_out_status <= r_hold_status;
            r_out_reload <= r_hold_reload;
            r_out_last   <= w_flush;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out_kind;
    assign o_res.slot         = r_out_slot;
    assign o_res.status       = r_out_status;
    assign o_res.reload_value = r_out_reload;
    assign o_res.last         = r_out_last;

endmodule

// ----- sim/time_triggered_task_dispatcher_unit_test.sv -----
// self-checking testbench of the time-triggered task dispatcher: predicted results vs dut
`timescale 1ns / 1ps
module time_triggered_task_dispatcher_unit_test;
    import ttd_pkg::*;

    localparam int NSLOTS        = TASK_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 2 * (NSLOTS + 3) + 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              status;
        logic [WORD_W-1:0] reload_value;
        logic              last;
    } t_sched_event;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WORD_W-1:0]    cfg_data;

    ttd_in_if  req_if ();
    ttd_out_if res_if ();

    time_triggered_task_dispatcher_unit #(
        .TASK_SLOTS(NSLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // dispatcher state as predicted
    logic              slot_busy [NSLOTS];
    logic [WORD_W-1:0] slot_count [NSLOTS];
    logic [WORD_W-1:0] slot_period [NSLOTS];
    logic              reload_pending;
    logic [WORD_W-1:0] reload_now;
    logic [WORD_W-1:0] cfg_macro;
    logic [WORD_W-1:0] cfg_expected;
    logic [WORD_W-1:0] cfg_max_corr;

    t_sched_event dispatch_events [$];

    int mismatches     = 0;
    int cycles         = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_sched_event make_event(input logic [KIND_W-1:0] k, input int s,
                                                input logic st);
        t_sched_event e;
        e.kind         = k;
        e.slot         = s[SLOT_W-1:0];
        e.status       = st;
        e.reload_value = reload_now;
        e.last         = 1'b0;
        return e;
    endfunction

    function automatic void dispatch_step(input logic [ACTION_W-1:0] act,
                                          input logic [WORD_W-1:0] dly, per, rx);
        t_sched_event      evs [$];
        logic [WORD_W-1:0] diff;
        int                free_slot;
        free_slot = -1;
        case (act)
            ACT_TICK: begin
                if (reload_pending) begin
                    reload_pending = 1'b0;
                    reload_now     = cfg_macro;
                    evs.push_back(make_event(KIND_RELOAD, 0, ST_ACCEPTED));
                end
                for (int s = 0; s < NSLOTS; s++) begin
                    if (slot_busy[s]) begin
                        // zero behaves like one: due on this tick
                        if (slot_count[s] <= 1) begin
                            slot_count[s] = slot_period[s];
                            if (evs.size() < RES_LIMIT)
                                evs.push_back(make_event(KIND_DUE, s, ST_ACCEPTED));
                        end else begin
                            slot_count[s] = slot_count[s] - 1;
                        end
                    end
                end
            end
            ACT_ADD: begin
                for (int s = NSLOTS - 1; s >= 0; s--)
                    if (!slot_busy[s]) free_slot = s;
                if (free_slot >= 0) begin
                    slot_busy[free_slot]   = 1'b1;
                    slot_count[free_slot]  = dly;
                    slot_period[free_slot] = per;
                    evs.push_back(make_event(KIND_ADD, free_slot, ST_ACCEPTED));
                end else begin
                    evs.push_back(make_event(KIND_ADD, 0, ST_FULL));
                end
            end
            ACT_SYNC: begin
                if (rx > cfg_expected) begin
                    diff = rx - cfg_expected;
                    if (diff > cfg_max_corr) diff = cfg_max_corr;
                    reload_now = (cfg_macro > ~diff) ? '1 : cfg_macro + diff;
                end else begin
                    diff = cfg_expected - rx;
                    if (diff > cfg_max_corr) diff = cfg_max_corr;
                    reload_now = (cfg_macro < diff) ? '0 : cfg_macro - diff;
                end
                reload_pending = 1'b1;
                evs.push_back(make_event(KIND_RELOAD, 0, ST_ACCEPTED));
            end
            default: ;
        endcase
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[k]) dispatch_events.push_back(evs[k]);
    endfunction

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge clk) begin
        if (hold_len != 0) begin
            res_if.ready <= 1'b0;
            hold_len     <= hold_len - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_sched_event want;
        t_sched_event got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = '{kind: res_if.kind, slot: res_if.slot, status: res_if.status,
                    reload_value: res_if.reload_value, last: res_if.last};
            if (dispatch_events.size() == 0) begin
                if (mismatches < 10)
                    $display({"%0t: unexpected result kind %0d slot %0d status %0d",
                              " reload %h last %0d"},
                             $time, got.kind, got.slot, got.status, got.reload_value, got.last);
                mismatches++;
            end else begin
                want = dispatch_events.pop_front();
                if (got.kind !== want.kind || got.slot !== want.slot ||
                    got.status !== want.status || got.reload_value !== want.reload_value ||
                    got.last !== want.last) begin
                    if (mismatches < 10) begin
                        $display("%0t: mismatch", $time);
                        $display("  want kind %0d slot %0d status %0d reload %h last %0d",
                                 want.kind, want.slot, want.status, want.reload_value,
                                 want.last);
                        $display("  got  kind %0d slot %0d status %0d reload %h last %0d",
                                 got.kind, got.slot, got.status, got.reload_value, got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [WORD_W-1:0] dly,
                            input logic [WORD_W-1:0] per, input logic [WORD_W-1:0] rx);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= act;
        req_if.initial_delay <= dly;
        req_if.period        <= per;
        req_if.rx_timestamp  <= rx;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        dispatch_step(act, dly, per, rx);
        @(negedge clk);
    endtask

    // drop valid, wait for every predicted result, then let a silent request finish
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (dispatch_events.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic [WORD_W-1:0] mp, input logic [WORD_W-1:0] et,
                                input logic [WORD_W-1:0] mc);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MACRO_PERIOD;
        cfg_data <= mp;
        @(negedge clk);
        cfg_idx  <= REG_EXPECTED_TS;
        cfg_data <= et;
        @(negedge clk);
        cfg_idx  <= REG_MAX_CORRECTION;
        cfg_data <= mc;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_macro    = mp;
        cfg_expected = et;
        cfg_max_corr = mc;
    endtask

    task automatic test_empty_table();
        send_req(ACT_TICK, '0, '0, '0);        // quiet tick
        send_req(ACT_NONE, '1, '1, '1);        // undefined action is ignored
    endtask

    task automatic test_add_and_tick();
        send_req(ACT_ADD, 32'd0, 32'd0, '0);   // zero delay and zero period
        send_req(ACT_ADD, '1, '1, '0);
        send_req(ACT_ADD, 32'd1, 32'd1, '0);
        send_req(ACT_ADD, 32'd3, 32'd2, '0);
        repeat (4) send_req(ACT_TICK, '1, '0, '1);
    endtask

    task automatic test_sync_correction();
        send_req(ACT_SYNC, '0, '0, cfg_expected);
        send_req(ACT_SYNC, '0, '0, 32'd0);
        send_req(ACT_SYNC, '0, '0, '1);         // repeated sync replaces the reload
        send_req(ACT_TICK, '0, '0, '0);         // restore ahead of due results
    endtask

    task automatic test_sync_bounds();
        write_config(32'hFFFF_FFF0, 32'd0, '1);
        send_req(ACT_SYNC, '0, '0, '1);         // raised reload saturates high
        send_req(ACT_TICK, '0, '0, '0);
        write_config(32'd5, '1, '1);
        send_req(ACT_SYNC, '0, '0, 32'd0);      // lowered reload saturates at zero
        // new macro period shows up only on the restoring tick
        write_config(32'd12345, 32'd100, 32'd0);
        send_req(ACT_TICK, '0, '0, '0);
        send_req(ACT_SYNC, '0, '0, 32'd200);    // no correction allowed
        send_req(ACT_TICK, '0, '0, '0);
    endtask

    task automatic test_table_full();
        repeat (NSLOTS - 4)
            send_req(ACT_ADD, $urandom_range(6), $urandom_range(1, 6), '0);
        send_req(ACT_ADD, 32'd7, 32'd7, '0);    // no free slot left
    endtask

    task automatic test_backpressure();
        wait_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(posedge clk);
        hold_len = 300;
        @(negedge clk);
        repeat (6) begin
            send_req(ACT_SYNC, '0, '0, $urandom);
            send_req(ACT_TICK, '0, '0, '0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct,
                                       input logic [WORD_W-1:0] mp,
                                       input logic [WORD_W-1:0] et,
                                       input logic [WORD_W-1:0] mc);
        int                sent;
        int                pick;
        logic [WORD_W-1:0] rx;
        write_config(mp, et, mc);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_req(ACT_TICK, $urandom, $urandom, $urandom);
                sent++;
            end else if (pick < 75) begin
                if ($urandom_range(2) == 0) rx = $urandom;
                else rx = cfg_expected + $urandom_range(200) - 100;
                send_req(ACT_SYNC, $urandom, $urandom, rx);
                sent++;
            end else if (pick < 90) begin
                send_req(ACT_ADD, $urandom, $urandom, $urandom);
                sent++;
            end else begin
                send_req(ACT_NONE, $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = REG_MACRO_PERIOD;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_TICK;
        req_if.initial_delay = '0;
        req_if.period        = '0;
        req_if.rx_timestamp  = '0;
        res_if.ready         = 1'b0;
        foreach (slot_busy[s]) begin
            slot_busy[s]   = 1'b0;
            slot_count[s]  = '0;
            slot_period[s] = '0;
        end
        reload_pending = 1'b0;
        reload_now     = MACRO_PERIOD_RST;
        cfg_macro      = MACRO_PERIOD_RST;
        cfg_expected   = EXPECTED_TS_RST;
        cfg_max_corr   = MAX_CORRECTION_RST;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        test_empty_table();
        test_add_and_tick();
        test_sync_correction();
        test_sync_bounds();
        test_table_full();
        test_backpressure();
        test_random_traffic(72, 0, 0, 32'd999, 32'd500, 32'd50);
        test_random_traffic(72, 82, 0, $urandom, $urandom, $urandom);
        test_random_traffic(72, 0, 82, 32'd1000, '1, '1);
        test_random_traffic(72, 13, 13, '1, 32'd0, $urandom_range(100));

        wait_idle();
        if (mismatches == 0 && dispatch_events.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
